### rtl/ccr_pkg.sv
// Package for the circle collision response block.
// Holds the fixed-point constants of the unit normal; no dependencies.
package ccr_pkg;

    // Fraction bits of the unit normal components.
    localparam int NORM_FRAC = 16;

    // The half-penetration push drops one more bit than the normal scaling.
    localparam int PUSH_SHIFT = NORM_FRAC + 1;

endpackage

### rtl/ccr_req_if.sv
// Request channel: one pair of circles per transaction.
// Depends on nothing; the value width is a parameter of the interface.
interface ccr_req_if #(
    parameter int VALUE_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] pos_a_x;
    logic signed [VALUE_WIDTH-1:0] pos_a_y;
    logic signed [VALUE_WIDTH-1:0] vel_a_x;
    logic signed [VALUE_WIDTH-1:0] vel_a_y;
    logic        [VALUE_WIDTH-2:0] radius_a;
    logic signed [VALUE_WIDTH-1:0] pos_b_x;
    logic signed [VALUE_WIDTH-1:0] pos_b_y;
    logic signed [VALUE_WIDTH-1:0] vel_b_x;
    logic signed [VALUE_WIDTH-1:0] vel_b_y;
    logic        [VALUE_WIDTH-2:0] radius_b;

    modport source (
        output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
               pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
               pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b,
        output ready
    );
endinterface

### rtl/ccr_rsp_if.sv
// Response channel: the two circles after the collision, per transaction.
// Depends on nothing; the value width is a parameter of the interface.
interface ccr_rsp_if #(
    parameter int VALUE_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_pos_a_x;
    logic signed [VALUE_WIDTH-1:0] new_pos_a_y;
    logic signed [VALUE_WIDTH-1:0] new_vel_a_x;
    logic signed [VALUE_WIDTH-1:0] new_vel_a_y;
    logic signed [VALUE_WIDTH-1:0] new_pos_b_x;
    logic signed [VALUE_WIDTH-1:0] new_pos_b_y;
    logic signed [VALUE_WIDTH-1:0] new_vel_b_x;
    logic signed [VALUE_WIDTH-1:0] new_vel_b_y;
    logic                          coincident;

    modport source (
        output valid, new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y,
               new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y, coincident,
        input  ready
    );
    modport sink (
        input  valid, new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y,
               new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y, coincident,
        output ready
    );
endinterface

### rtl/circle_collision_response.sv
// Top level of the equal-mass elastic circle collision response pipeline.
// Depends on ccr_pkg, ccr_req_if and ccr_rsp_if.
//
// Channel  Direction  Contents
// req      in         two circles: centre, velocity and radius each
// rsp      out        both circles after impulse and push, coincident flag
//
// One transaction enters per cycle while rsp is not stalled; there are
// VALUE_WIDTH + 29 register stages, among them VALUE_WIDTH + 2 square-root
// steps and 17 divider steps.
// Reset clears only the valid bits of the stages; payload is not reset.
// When rsp is stalled with a result waiting, every stage holds and req.ready
// drops; bubbles ahead of a full output stage are not squeezed out.
module circle_collision_response
    import ccr_pkg::*;
#(
    parameter int VALUE_WIDTH = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    ccr_req_if.sink       req,
    ccr_rsp_if.source     rsp
);

    localparam int W    = VALUE_WIDTH;
    localparam int AW   = W + 1;              // magnitude of a centre difference
    localparam int XW   = 2 * AW + 3;         // square-root remainder
    localparam int RW   = AW + 1;             // root bits
    localparam int DW   = AW + 2;             // distance after the range shift
    localparam int NDW  = W + NORM_FRAC + 3;  // divider remainder
    localparam int QW   = NORM_FRAC + 1;      // normal magnitude bits
    localparam int NXW  = NORM_FRAC + 2;      // signed normal component
    localparam int PW   = W + 4;              // penetration
    localparam int IW   = W + 3;              // impulse
    localparam int HW   = W + 4;              // push and impulse components
    localparam int PPW  = W + NORM_FRAC + 6;  // products
    localparam int MAXW = PPW + 2;

    // Stage numbering.
    localparam int S_IN   = 0;
    localparam int S_SQ   = 1;
    localparam int S_SUM  = 2;
    localparam int S_RT0  = 3;
    localparam int S_D    = S_RT0 + RW;
    localparam int S_DV0  = S_D + 1;
    localparam int S_NRM  = S_DV0 + QW;
    localparam int S_MUL1 = S_NRM + 1;
    localparam int S_RND1 = S_MUL1 + 1;
    localparam int S_MUL2 = S_RND1 + 1;
    localparam int S_RND2 = S_MUL2 + 1;
    localparam int S_OUT  = S_RND2 + 1;
    localparam int LAST   = S_OUT;

    typedef struct packed {
        logic signed [W-1:0]   pa_x;
        logic signed [W-1:0]   pa_y;
        logic signed [W-1:0]   va_x;
        logic signed [W-1:0]   va_y;
        logic        [W-2:0]   ra;
        logic signed [W-1:0]   pb_x;
        logic signed [W-1:0]   pb_y;
        logic signed [W-1:0]   vb_x;
        logic signed [W-1:0]   vb_y;
        logic        [W-2:0]   rb;
        logic                  coin;
        logic                  sh;
        logic                  neg_x;
        logic                  neg_y;
        logic        [AW-1:0]  mx;
        logic        [AW-1:0]  my;
        logic        [XW-1:0]  sqx;
        logic        [XW-1:0]  sqy;
        logic        [XW-1:0]  rem;
        logic        [RW-1:0]  root;
        logic        [DW-1:0]  d;
        logic        [NDW-1:0] remx;
        logic        [NDW-1:0] remy;
        logic        [QW-1:0]  qx;
        logic        [QW-1:0]  qy;
        logic signed [PW-1:0]  pen;
        logic signed [NXW-1:0] nx;
        logic signed [NXW-1:0] ny;
        logic signed [PPW-1:0] pix;
        logic signed [PPW-1:0] piy;
        logic signed [PPW-1:0] phx;
        logic signed [PPW-1:0] phy;
        logic signed [IW-1:0]  imp;
        logic signed [HW-1:0]  hx;
        logic signed [HW-1:0]  hy;
        logic signed [HW-1:0]  kx;
        logic signed [HW-1:0]  ky;
    } ctx_t;

    // Arithmetic shift right with rounding half away from zero.
    function automatic logic signed [MAXW-1:0] rnd_shr(
        input logic signed [MAXW-1:0] v,
        input int                     sh
    );
        logic signed [MAXW-1:0] half;
        logic signed [MAXW-1:0] adj;
        half = MAXW'(1) <<< (sh - 1);
        adj  = v[MAXW-1] ? MAXW'(-1) : MAXW'(0);
        return (v + half + adj) >>> sh;
    endfunction

    // Clamp to the signed value range.
    function automatic logic signed [W-1:0] sat(input logic signed [MAXW-1:0] v);
        logic signed [MAXW-1:0] hi;
        logic signed [MAXW-1:0] lo;
        hi = (MAXW'(1) <<< (W - 1)) - MAXW'(1);
        lo = -(MAXW'(1) <<< (W - 1));
        if (v > hi) begin
            return hi[W-1:0];
        end
        if (v < lo) begin
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    ctx_t            pipe_reg   [0:LAST];
    ctx_t            stage_next [0:LAST];
    logic [LAST:0]   valid_reg;
    logic            adv;

    // The whole pipeline moves unless a finished result is held at the output.
    assign adv       = !valid_reg[LAST] || rsp.ready;
    assign req.ready = adv;

    genvar g;
    generate
        for (g = 0; g <= LAST; g++) begin : g_stage
            if (g == S_IN) begin : g_in
                // Centre difference, its magnitudes and the range shift.
                always_comb
                begin
                    logic signed [AW-1:0] dx;
                    logic signed [AW-1:0] dy;
                    stage_next[g]      = '0;
                    stage_next[g].pa_x = req.pos_a_x;
                    stage_next[g].pa_y = req.pos_a_y;
                    stage_next[g].va_x = req.vel_a_x;
                    stage_next[g].va_y = req.vel_a_y;
                    stage_next[g].ra   = req.radius_a;
                    stage_next[g].pb_x = req.pos_b_x;
                    stage_next[g].pb_y = req.pos_b_y;
                    stage_next[g].vb_x = req.vel_b_x;
                    stage_next[g].vb_y = req.vel_b_y;
                    stage_next[g].rb   = req.radius_b;
                    dx = AW'(req.pos_b_x) - AW'(req.pos_a_x);
                    dy = AW'(req.pos_b_y) - AW'(req.pos_a_y);
                    stage_next[g].neg_x = dx[AW-1];
                    stage_next[g].neg_y = dy[AW-1];
                    stage_next[g].mx    = dx[AW-1] ? AW'(-dx) : AW'(dx);
                    stage_next[g].my    = dy[AW-1] ? AW'(-dy) : AW'(dy);
                    stage_next[g].coin  = (dx == '0) && (dy == '0);
                    stage_next[g].sh    = (64'(stage_next[g].mx) >= 64'h8000_0000)
                                       || (64'(stage_next[g].my) >= 64'h8000_0000);
                end
            end else if (g == S_SQ) begin : g_sq
                // Squares of the (possibly halved) magnitudes.
                always_comb
                begin
                    logic [AW-1:0] ax;
                    logic [AW-1:0] ay;
                    stage_next[g] = pipe_reg[g-1];
                    ax = pipe_reg[g-1].sh ? (pipe_reg[g-1].mx >> 1) : pipe_reg[g-1].mx;
                    ay = pipe_reg[g-1].sh ? (pipe_reg[g-1].my >> 1) : pipe_reg[g-1].my;
                    stage_next[g].sqx = XW'(ax) * XW'(ax);
                    stage_next[g].sqy = XW'(ay) * XW'(ay);
                end
            end else if (g == S_SUM) begin : g_sum
                // Sum of squares seeds the square-root remainder.
                always_comb
                begin
                    stage_next[g]      = pipe_reg[g-1];
                    stage_next[g].rem  = pipe_reg[g-1].sqx + pipe_reg[g-1].sqy;
                    stage_next[g].root = '0;
                end
            end else if (g < S_D) begin : g_root
                // One root bit per stage, restoring form.
                localparam int I = RW - 1 - (g - S_RT0);
                always_comb
                begin
                    logic [XW-1:0] t;
                    stage_next[g] = pipe_reg[g-1];
                    t = (XW'(pipe_reg[g-1].root) << (I + 1)) | (XW'(1) << (2 * I));
                    if (pipe_reg[g-1].rem >= t) begin
                        stage_next[g].rem     = pipe_reg[g-1].rem - t;
                        stage_next[g].root[I] = 1'b1;
                    end
                end
            end else if (g == S_D) begin : g_dist
                // Round the root to nearest, undo the range shift, set up the
                // dividers and the penetration.
                always_comb
                begin
                    logic [RW-1:0] r;
                    stage_next[g] = pipe_reg[g-1];
                    r = pipe_reg[g-1].root;
                    if (pipe_reg[g-1].rem > XW'(r)) begin
                        r = r + RW'(1);
                    end
                    stage_next[g].d    = DW'(r) << pipe_reg[g-1].sh;
                    stage_next[g].pen  = PW'(pipe_reg[g-1].ra) + PW'(pipe_reg[g-1].rb)
                                       - PW'(stage_next[g].d);
                    stage_next[g].remx = (NDW'(pipe_reg[g-1].mx) << NORM_FRAC)
                                       + NDW'(stage_next[g].d >> 1);
                    stage_next[g].remy = (NDW'(pipe_reg[g-1].my) << NORM_FRAC)
                                       + NDW'(stage_next[g].d >> 1);
                    stage_next[g].qx   = '0;
                    stage_next[g].qy   = '0;
                end
            end else if (g < S_NRM) begin : g_div
                // One quotient bit per stage for both normal components.
                localparam int I = QW - 1 - (g - S_DV0);
                always_comb
                begin
                    logic [NDW-1:0] t;
                    stage_next[g] = pipe_reg[g-1];
                    t = NDW'(pipe_reg[g-1].d) << I;
                    if (pipe_reg[g-1].remx >= t) begin
                        stage_next[g].remx  = pipe_reg[g-1].remx - t;
                        stage_next[g].qx[I] = 1'b1;
                    end
                    if (pipe_reg[g-1].remy >= t) begin
                        stage_next[g].remy  = pipe_reg[g-1].remy - t;
                        stage_next[g].qy[I] = 1'b1;
                    end
                end
            end else if (g == S_NRM) begin : g_nrm
                // Signed normal components.
                always_comb
                begin
                    stage_next[g]    = pipe_reg[g-1];
                    stage_next[g].nx = pipe_reg[g-1].neg_x ? -NXW'(pipe_reg[g-1].qx)
                                                           :  NXW'(pipe_reg[g-1].qx);
                    stage_next[g].ny = pipe_reg[g-1].neg_y ? -NXW'(pipe_reg[g-1].qy)
                                                           :  NXW'(pipe_reg[g-1].qy);
                end
            end else if (g == S_MUL1) begin : g_mul1
                // Relative velocity and penetration times the normal.
                always_comb
                begin
                    logic signed [PPW-1:0] dvx;
                    logic signed [PPW-1:0] dvy;
                    stage_next[g] = pipe_reg[g-1];
                    dvx = PPW'(pipe_reg[g-1].vb_x) - PPW'(pipe_reg[g-1].va_x);
                    dvy = PPW'(pipe_reg[g-1].vb_y) - PPW'(pipe_reg[g-1].va_y);
                    stage_next[g].pix = dvx * PPW'(pipe_reg[g-1].nx);
                    stage_next[g].piy = dvy * PPW'(pipe_reg[g-1].ny);
                    stage_next[g].phx = PPW'(pipe_reg[g-1].pen) * PPW'(pipe_reg[g-1].nx);
                    stage_next[g].phy = PPW'(pipe_reg[g-1].pen) * PPW'(pipe_reg[g-1].ny);
                end
            end else if (g == S_RND1) begin : g_rnd1
                // Impulse and half-penetration push.
                always_comb
                begin
                    logic signed [MAXW-1:0] t;
                    stage_next[g] = pipe_reg[g-1];
                    t = rnd_shr(MAXW'(pipe_reg[g-1].pix) + MAXW'(pipe_reg[g-1].piy),
                                NORM_FRAC);
                    stage_next[g].imp = t[IW-1:0];
                    t = rnd_shr(MAXW'(pipe_reg[g-1].phx), PUSH_SHIFT);
                    stage_next[g].hx  = t[HW-1:0];
                    t = rnd_shr(MAXW'(pipe_reg[g-1].phy), PUSH_SHIFT);
                    stage_next[g].hy  = t[HW-1:0];
                end
            end else if (g == S_MUL2) begin : g_mul2
                // Impulse times the normal.
                always_comb
                begin
                    stage_next[g]     = pipe_reg[g-1];
                    stage_next[g].pix = PPW'(pipe_reg[g-1].imp) * PPW'(pipe_reg[g-1].nx);
                    stage_next[g].piy = PPW'(pipe_reg[g-1].imp) * PPW'(pipe_reg[g-1].ny);
                end
            end else if (g == S_RND2) begin : g_rnd2
                // Impulse components along the normal.
                always_comb
                begin
                    logic signed [MAXW-1:0] t;
                    stage_next[g] = pipe_reg[g-1];
                    t = rnd_shr(MAXW'(pipe_reg[g-1].pix), NORM_FRAC);
                    stage_next[g].kx = t[HW-1:0];
                    t = rnd_shr(MAXW'(pipe_reg[g-1].piy), NORM_FRAC);
                    stage_next[g].ky = t[HW-1:0];
                end
            end else begin : g_out
                // Apply impulse and push with saturation; coincident centres
                // pass straight through.
                always_comb
                begin
                    ctx_t c;
                    c = pipe_reg[g-1];
                    stage_next[g] = c;
                    if (!c.coin) begin
                        stage_next[g].pa_x = sat(MAXW'(c.pa_x) - MAXW'(c.hx));
                        stage_next[g].pa_y = sat(MAXW'(c.pa_y) - MAXW'(c.hy));
                        stage_next[g].va_x = sat(MAXW'(c.va_x) + MAXW'(c.kx));
                        stage_next[g].va_y = sat(MAXW'(c.va_y) + MAXW'(c.ky));
                        stage_next[g].pb_x = sat(MAXW'(c.pb_x) + MAXW'(c.hx));
                        stage_next[g].pb_y = sat(MAXW'(c.pb_y) + MAXW'(c.hy));
                        stage_next[g].vb_x = sat(MAXW'(c.vb_x) - MAXW'(c.kx));
                        stage_next[g].vb_y = sat(MAXW'(c.vb_y) - MAXW'(c.ky));
                    end
                end
            end
        end
    endgenerate

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAST-1:0], req.valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int k = 0; k <= LAST; k++) begin
                pipe_reg[k] <= stage_next[k];
            end
        end
    end

    // Response fields come straight from the output stage.
    assign rsp.valid       = valid_reg[LAST];
    assign rsp.new_pos_a_x = pipe_reg[LAST].pa_x;
    assign rsp.new_pos_a_y = pipe_reg[LAST].pa_y;
    assign rsp.new_vel_a_x = pipe_reg[LAST].va_x;
    assign rsp.new_vel_a_y = pipe_reg[LAST].va_y;
    assign rsp.new_pos_b_x = pipe_reg[LAST].pb_x;
    assign rsp.new_pos_b_y = pipe_reg[LAST].pb_y;
    assign rsp.new_vel_b_x = pipe_reg[LAST].vb_x;
    assign rsp.new_vel_b_y = pipe_reg[LAST].vb_y;
    assign rsp.coincident  = pipe_reg[LAST].coin;

    // A stalled pipeline keeps every valid bit where it was.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline valid bits moved during a stall");

    // Distinct centres always give a non-zero distance to divide by.
    a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_D] && !pipe_reg[S_D].coin |-> pipe_reg[S_D].d != '0)
        else $error("zero distance for distinct centres");

    // Normal components never exceed one.
    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_NRM] && !pipe_reg[S_NRM].coin |->
            pipe_reg[S_NRM].qx <= QW'(1 << NORM_FRAC)
            && pipe_reg[S_NRM].qy <= QW'(1 << NORM_FRAC))
        else $error("normal component above one");

endmodule

### tb/sv/circle_collision_response_checker.sv
// Checker for the circle collision response block: predicts each response
// from the accepted request and compares it field by field.
// Depends on ccr_pkg, ccr_req_if and ccr_rsp_if.
`timescale 1ns / 1ps

module circle_collision_response_checker
    import ccr_pkg::*;
#(
    parameter int VALUE_WIDTH = 24
) (
    input  logic clk,
    input  logic rst_n,
    ccr_req_if   req,
    ccr_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct {
        value_t pos_a_x, pos_a_y, vel_a_x, vel_a_y;
        value_t pos_b_x, pos_b_y, vel_b_x, vel_b_y;
        logic   coincident;
    } collision_result_t;

    collision_result_t pending_results[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Division and shift with rounding half away from zero.
    function automatic longint shift_round(longint v, int s);
        longint m;
        m = ((v < 0 ? -v : v) + (longint'(1) <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint divide_round(longint num, longint den);
        longint m;
        m = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -m : m;
    endfunction

    // Square root rounded to the nearest integer.
    function automatic longint sqrt_nearest(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (x > r)
            r = r + 1;
        return longint'(r);
    endfunction

    function automatic value_t saturate(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
        lo = -(longint'(1) <<< (VALUE_WIDTH - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return value_t'(v);
    endfunction

    // Impulse along the normal, then the half-penetration push.
    function automatic collision_result_t resolve_collision();
        collision_result_t res;
        longint pax, pay, vax, vay, ra, pbx, pby, vbx, vby, rb;
        longint dx, dy, ax, ay, distance, nx, ny, imp, kx, ky, pen, hx, hy;
        int sh;
        pax = req.pos_a_x; pay = req.pos_a_y; vax = req.vel_a_x; vay = req.vel_a_y;
        pbx = req.pos_b_x; pby = req.pos_b_y; vbx = req.vel_b_x; vby = req.vel_b_y;
        ra  = longint'({1'b0, req.radius_a});
        rb  = longint'({1'b0, req.radius_b});
        dx  = pbx - pax;
        dy  = pby - pay;
        if (dx == 0 && dy == 0)
        begin
            res = '{saturate(pax), saturate(pay), saturate(vax), saturate(vay),
                    saturate(pbx), saturate(pby), saturate(vbx), saturate(vby), 1'b1};
            return res;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sh = (ax >= (longint'(1) <<< 31) || ay >= (longint'(1) <<< 31)) ? 1 : 0;
        ax = ax >>> sh;
        ay = ay >>> sh;
        distance = sqrt_nearest(ax * ax + ay * ay) <<< sh;
        nx  = divide_round(dx * (longint'(1) <<< NORM_FRAC), distance);
        ny  = divide_round(dy * (longint'(1) <<< NORM_FRAC), distance);
        imp = shift_round((vbx - vax) * nx + (vby - vay) * ny, NORM_FRAC);
        kx  = shift_round(imp * nx, NORM_FRAC);
        ky  = shift_round(imp * ny, NORM_FRAC);
        pen = ra + rb - distance;
        hx  = shift_round(pen * nx, PUSH_SHIFT);
        hy  = shift_round(pen * ny, PUSH_SHIFT);
        res = '{saturate(pax - hx), saturate(pay - hy), saturate(vax + kx),
                saturate(vay + ky), saturate(pbx + hx), saturate(pby + hy),
                saturate(vbx - kx), saturate(vby - ky), 1'b0};
        return res;
    endfunction

    task automatic compare_field(string name, value_t want, value_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Record each request transaction and check each response transaction.
    always @(posedge clk)
    begin
        collision_result_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                pending_results.push_back(resolve_collision());
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("response transaction with no request waiting");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("new_pos_a_x", want.pos_a_x, rsp.new_pos_a_x);
                    compare_field("new_pos_a_y", want.pos_a_y, rsp.new_pos_a_y);
                    compare_field("new_vel_a_x", want.vel_a_x, rsp.new_vel_a_x);
                    compare_field("new_vel_a_y", want.vel_a_y, rsp.new_vel_a_y);
                    compare_field("new_pos_b_x", want.pos_b_x, rsp.new_pos_b_x);
                    compare_field("new_pos_b_y", want.pos_b_y, rsp.new_pos_b_y);
                    compare_field("new_vel_b_x", want.vel_b_x, rsp.new_vel_b_x);
                    compare_field("new_vel_b_y", want.vel_b_y, rsp.new_vel_b_y);
                    if (want.coincident !== rsp.coincident)
                    begin
                        $error("coincident: expected %0d, got %0d",
                               want.coincident, rsp.coincident);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

### tb/sv/circle_collision_response_tb.sv
// Top of the circle collision response testbench: clock, reset, request
// stimulus, response back-pressure and the verdict. Uses the RTL and the checker.
`timescale 1ns / 1ps

module circle_collision_response_tb;

    localparam int VALUE_WIDTH = 24;
    localparam int RANDOM_PAIRS = 930;
    localparam logic [23:0] VMAX = 24'h7FFFFF;
    localparam logic [23:0] VMIN = 24'h800000;
    localparam logic [22:0] RMAX = 23'h7FFFFF;

    logic clk;
    logic rst_n;
    logic steady_sink;
    int   mismatches;
    int   outstanding;

    ccr_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req ();
    ccr_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp ();

    circle_collision_response #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    circle_collision_response_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock.
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The response side stalls at random about six percent of the time, except in a stretch.
    always @(posedge clk)
        rsp.ready <= steady_sink || ($urandom_range(0, 99) >= 6);

    // Signed value of the given width, sign-extended to the field.
    function automatic logic [23:0] random_signed(int bits);
        return 24'(longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) <<< (bits - 1)));
    endfunction

    // Present one pair of circles and hold it until the transaction completes.
    task automatic send_pair(logic [23:0] pax, logic [23:0] pay, logic [23:0] vax,
                             logic [23:0] vay, logic [22:0] ra, logic [23:0] pbx,
                             logic [23:0] pby, logic [23:0] vbx, logic [23:0] vby,
                             logic [22:0] rb, bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 6)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.pos_a_x  <= pax;
        req.pos_a_y  <= pay;
        req.vel_a_x  <= vax;
        req.vel_a_y  <= vay;
        req.radius_a <= ra;
        req.pos_b_x  <= pbx;
        req.pos_b_y  <= pby;
        req.vel_b_x  <= vbx;
        req.vel_b_y  <= vby;
        req.radius_b <= rb;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Pause the sender until every response has arrived.
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Stimulus: directed corner cases, then random pairs.
    initial
    begin
        logic [23:0] pax, pay, dlx, dly;
        int kind;
        rst_n       = 1'b0;
        steady_sink = 1'b0;
        req.valid   = 1'b0;
        rsp.ready   = 1'b0;
        {req.pos_a_x, req.pos_a_y, req.vel_a_x, req.vel_a_y, req.radius_a} = '0;
        {req.pos_b_x, req.pos_b_y, req.vel_b_x, req.vel_b_y, req.radius_b} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coincident centres, including the extremes of every field.
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(VMAX, VMIN, VMAX, VMIN, RMAX, VMAX, VMIN, VMIN, VMAX, RMAX, 0);
        send_pair(VMIN, VMAX, VMIN, VMAX, 0, VMIN, VMAX, VMAX, VMIN, 0, 0);
        // Separation along one axis only, both directions.
        send_pair(0, 0, 24'h100, 0, 23'h100, 24'h100, 0, 24'hFFFF00, 0, 23'h100, 0);
        send_pair(0, 0, 0, 24'h200, 23'h80, 0, 24'hFFFF80, 0, 24'hFFFE00, 23'h80, 0);
        send_pair(24'h300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Centres at opposite extremes: the widest distance.
        send_pair(VMIN, VMIN, 0, 0, 0, VMAX, VMAX, 0, 0, 0, 0);
        send_pair(VMAX, VMAX, VMAX, VMAX, RMAX, VMIN, VMIN, VMIN, VMIN, RMAX, 0);
        send_pair(VMIN, VMAX, VMIN, VMIN, RMAX, VMAX, VMIN, VMAX, VMAX, RMAX, 0);
        // Velocities and pushes that saturate.
        send_pair(VMAX, 0, VMAX, VMAX, RMAX, 24'h7FFF00, 0, VMIN, VMIN, RMAX, 0);
        send_pair(VMIN, 1, VMIN, 0, RMAX, 24'h800001, 2, VMAX, 0, RMAX, 0);
        send_pair(0, 0, VMIN, VMAX, RMAX, 1, 1, VMAX, VMIN, RMAX, 0);
        // Smallest separations and diagonal normals.
        send_pair(0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
        send_pair(0, 0, 24'h1234, 24'hFEDCBA, 23'h400, 24'hFFFFFF, 24'hFFFFFF,
                  24'h000800, 24'h000900, 23'h400, 0);
        send_pair(24'h001000, 24'h002000, 24'h10, 24'h20, 23'h1000, 24'h001800,
                  24'h001800, 24'hFFFFF0, 24'hFFFFE0, 23'h1000, 0);
        send_pair(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 23'h555555,
                  24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 23'h2AAAAA, 0);
        drain();

        // Random pairs: mostly overlapping neighbours, some coincident, some noise.
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            steady_sink = (n >= 300 && n < 500);
            if (n == 600)
                drain();
            kind = $urandom_range(0, 99);
            pax  = random_signed(20);
            pay  = random_signed(20);
            dlx  = random_signed(13);
            dly  = random_signed(13);
            if (kind < 10)
                send_pair(pax, pay, random_signed(24), random_signed(24),
                          23'($urandom), pax, pay, random_signed(24),
                          random_signed(24), 23'($urandom), !steady_sink);
            else if (kind < 30)
                send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 23'($urandom), !steady_sink);
            else
                send_pair(pax, pay, random_signed(16), random_signed(16),
                          23'($urandom_range(0, 4096)), pax + dlx, pay + dly,
                          random_signed(16), random_signed(16),
                          23'($urandom_range(0, 4096)), !steady_sink);
        end
        steady_sink = 1'b0;
        req.valid <= 1'b0;

        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (2 * VALUE_WIDTH + 40) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### circle_collision_response.f
rtl/ccr_pkg.sv
rtl/ccr_req_if.sv
rtl/ccr_rsp_if.sv
rtl/circle_collision_response.sv
tb/sv/circle_collision_response_checker.sv
tb/sv/circle_collision_response_tb.sv
